// ===== rtl/core/ops_pkg.sv =====
// ----------------------------------------------------------------------------
// ops_pkg: shared definitions for the odd-only prime sieve
// Field widths, parameter defaults and the tally control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ops_pkg;

  // Fixed field widths
  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned COUNT_W = 20;
  localparam int unsigned SUM_W   = 36;

  // Parameter defaults
  localparam int unsigned MAX_LIMIT_DEF = 1048576;
  localparam int unsigned WORD_BITS_DEF = 64;

  // Control from the sieve engine to the count/sum accumulator
  typedef struct packed {
    logic start;  // new request: load initial tally
    logic seed;   // limit >= 2, so the prime 2 is counted
    logic step;   // advance to the next odd candidate
    logic take;   // current odd candidate is prime
  } tally_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/odd_only_prime_sieve.sv =====
// Operation: all NumWords bitmap words are cleared (8193 by default), then each
//   outer candidate up to sqrt(limit) is read and each of its marked multiples
//   gets a bitmap RAM read-modify-write, then the scan takes one odd number per
//   cycle between word reads; the result is registered at the output.
// Throughput: one request at a time; a new request is taken while a result waits.
// Reset: control and output valid clear at once; the bitmap is cleared per request.
// ----------------------------------------------------------------------------
// odd_only_prime_sieve: counts and sums the primes up to a limit
// Sieve of Eratosthenes over an odd-only bitmap held in one RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module odd_only_prime_sieve #(
  parameter int unsigned MaxLimit = ops_pkg::MAX_LIMIT_DEF,
  parameter int unsigned WordBits = ops_pkg::WORD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ops_pkg::LIMIT_W-1:0]   limit_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ops_pkg::COUNT_W-1:0]        prime_count_o,
  output logic [ops_pkg::SUM_W-1:0]          prime_sum_o,
  output logic                               was_clamped_o
);

  localparam int unsigned NumWords = (MaxLimit / 2 + WordBits - 1) / WordBits + 1;
  localparam int unsigned AW       = $clog2(NumWords);

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WordBits-1:0]  ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [WordBits-1:0]  ram_rdata;

  ops_pkg::tally_ctrl_t tally_ctrl;
  logic [ops_pkg::COUNT_W-1:0] count;
  logic [ops_pkg::SUM_W-1:0]   sum;

  logic done;
  logic clamped;
  logic out_free;

  logic                        out_valid_q, out_valid_d;
  logic [ops_pkg::COUNT_W-1:0] count_q;
  logic [ops_pkg::SUM_W-1:0]   sum_q;
  logic                        clamped_q;

  // Composite bitmap
  ops_ram #(
    .Width (WordBits),
    .Depth (NumWords)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  ops_engine #(
    .MaxLimit (MaxLimit),
    .WordBits (WordBits)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .limit_i     (limit_i),
    .in_stall_o  (in_stall_o),
    .out_free_i  (out_free),
    .done_o      (done),
    .clamped_o   (clamped),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .tally_o     (tally_ctrl)
  );

  // Count and sum
  ops_tally #(
    .MaxLimit (MaxLimit)
  ) u_tally (
    .clk_i   (clk_i),
    .ctrl_i  (tally_ctrl),
    .count_o (count),
    .sum_o   (sum)
  );

  // Output register
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = done ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      count_q   <= count;
      sum_q     <= sum;
      clamped_q <= clamped;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign prime_count_o = count_q;
  assign prime_sum_o   = sum_q;
  assign was_clamped_o = clamped_q;

endmodule

`default_nettype wire

// ===== rtl/core/ops_ram.sv =====
// ----------------------------------------------------------------------------
// ops_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ops_ram #(
  parameter  int unsigned Width = 64,
  parameter  int unsigned Depth = 8192,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/ops_tally.sv =====
// ----------------------------------------------------------------------------
// ops_tally: prime count and sum accumulator
// Walks the odd candidates 1, 3, 5, ... in step with the bitmap scan and adds
// each one flagged prime to the running count and sum (both wrap).
// ----------------------------------------------------------------------------
`default_nettype none

module ops_tally #(
  parameter int unsigned MaxLimit = ops_pkg::MAX_LIMIT_DEF
) (
  input  wire logic                         clk_i,
  input  wire ops_pkg::tally_ctrl_t         ctrl_i,
  output logic [ops_pkg::COUNT_W-1:0]       count_o,
  output logic [ops_pkg::SUM_W-1:0]         sum_o
);

  localparam int unsigned LimW = $clog2(MaxLimit + 1);
  localparam int unsigned CntW = ops_pkg::COUNT_W;
  localparam int unsigned SumW = ops_pkg::SUM_W;

  logic [LimW-1:0] odd_q, odd_d;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] sum_q, sum_d;

  // Next tally
  always_comb begin
    odd_d   = odd_q;
    count_d = count_q;
    sum_d   = sum_q;
    if (ctrl_i.start) begin
      odd_d   = LimW'(1);
      count_d = ctrl_i.seed ? CntW'(1) : '0;
      sum_d   = ctrl_i.seed ? SumW'(2) : '0;
    end else begin
      if (ctrl_i.take) begin
        count_d = count_q + CntW'(1);
        sum_d   = sum_q + SumW'(odd_q);
      end
      if (ctrl_i.step) begin
        odd_d = odd_q + LimW'(2);
      end
    end
  end

  // Payload registers, loaded every cycle; the initial tally loads on request start
  always_ff @(posedge clk_i) begin
    odd_q   <= odd_d;
    count_q <= count_d;
    sum_q   <= sum_d;
  end

  assign count_o = count_q;
  assign sum_o   = sum_q;

endmodule

`default_nettype wire

// ===== rtl/core/ops_engine.sv =====
// ----------------------------------------------------------------------------
// ops_engine: sieve sequencer
// Clears the bitmap, runs the marking passes with read-modify-write on the RAM,
// then scans the bitmap for the tally, one bit per cycle between word reads.
// ----------------------------------------------------------------------------
`default_nettype none

module ops_engine #(
  parameter  int unsigned MaxLimit = ops_pkg::MAX_LIMIT_DEF,
  parameter  int unsigned WordBits = ops_pkg::WORD_BITS_DEF,
  localparam int unsigned NumWords = (MaxLimit / 2 + WordBits - 1) / WordBits + 1,
  localparam int unsigned AW       = $clog2(NumWords)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic [ops_pkg::LIMIT_W-1:0]   limit_i,
  output logic                               in_stall_o,
  input  wire logic                          out_free_i,
  output logic                               done_o,
  output logic                               clamped_o,
  output logic                               ram_we_o,
  output logic [AW-1:0]                      ram_waddr_o,
  output logic [WordBits-1:0]                ram_wdata_o,
  output logic                               ram_re_o,
  output logic [AW-1:0]                      ram_raddr_o,
  input  wire logic [WordBits-1:0]           ram_rdata_i,
  output ops_pkg::tally_ctrl_t               tally_o
);

  localparam int unsigned LW   = ops_pkg::LIMIT_W;
  localparam int unsigned LimW = $clog2(MaxLimit + 1);
  localparam int unsigned JW   = LimW + 1;
  localparam int unsigned IW   = LimW / 2 + 3;
  localparam int unsigned SqW  = 2 * IW;
  localparam int unsigned BW   = $clog2(WordBits);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CLEAR = 9'b000000010,
    ST_OCHK  = 9'b000000100,
    ST_OBIT  = 9'b000001000,
    ST_MRD   = 9'b000010000,
    ST_MWR   = 9'b000100000,
    ST_SRD   = 9'b001000000,
    ST_SBIT  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [LimW-1:0] lim_q, lim_d;
  logic [LimW-1:0] klim_q, klim_d;
  logic            clamped_q, clamped_d;
  // outer prime candidate i, its square, i split as word/bit, i/2 as word/bit
  logic [IW-1:0]   i_q, i_d;
  logic [SqW-1:0]  sq_q, sq_d;
  logic [AW-1:0]   qi_q, qi_d;
  logic [BW-1:0]   ri_q, ri_d;
  logic [AW-1:0]   wi_q, wi_d;
  logic [BW-1:0]   bi_q, bi_d;
  // marking multiple j and its bit position (word/bit), scan index k
  logic [JW-1:0]   j_q, j_d;
  logic [AW-1:0]   w_q, w_d;
  logic [BW-1:0]   b_q, b_d;
  logic [LimW-1:0] k_q, k_d;

  logic            accept;
  logic            over_max;
  logic [LimW-1:0] lim_new;

  // next-outer-candidate values
  logic [IW-1:0]   i_nx;
  logic [SqW-1:0]  sq_nx;
  logic [BW:0]     r2;
  logic [AW-1:0]   qi_nx;
  logic [BW-1:0]   ri_nx;
  logic [BW:0]     b1;
  logic [AW-1:0]   wi_nx;
  logic [BW-1:0]   bi_nx;

  // next-multiple values
  logic [JW-1:0]   j_nx;
  logic [BW:0]     bsum;
  logic            bcarry;
  logic [BW-1:0]   b_nx;
  logic [AW-1:0]   w_nx;

  // Request intake and clamping
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign over_max = limit_i > LW'(MaxLimit);
  assign lim_new  = over_max ? LimW'(MaxLimit) : limit_i[LimW-1:0];

  // Advance of the outer candidate: i += 2, square and split positions follow
  always_comb begin
    i_nx  = i_q + IW'(2);
    sq_nx = sq_q + SqW'({i_q, 2'b00}) + SqW'(4);
    r2    = {1'b0, ri_q} + (BW + 1)'(2);
    if (r2 >= (BW + 1)'(WordBits)) begin
      ri_nx = BW'(r2 - (BW + 1)'(WordBits));
      qi_nx = qi_q + AW'(1);
    end else begin
      ri_nx = BW'(r2);
      qi_nx = qi_q;
    end
    b1 = {1'b0, bi_q} + (BW + 1)'(1);
    if (b1 == (BW + 1)'(WordBits)) begin
      bi_nx = '0;
      wi_nx = wi_q + AW'(1);
    end else begin
      bi_nx = BW'(b1);
      wi_nx = wi_q;
    end
  end

  // Next multiple: j += 2i, bit position += i
  always_comb begin
    j_nx   = j_q + JW'({i_q, 1'b0});
    bsum   = {1'b0, b_q} + {1'b0, ri_q};
    bcarry = bsum >= (BW + 1)'(WordBits);
    b_nx   = bcarry ? BW'(bsum - (BW + 1)'(WordBits)) : BW'(bsum);
    w_nx   = w_q + qi_q + AW'(bcarry);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    lim_d     = lim_q;
    klim_d    = klim_q;
    clamped_d = clamped_q;
    i_d       = i_q;
    sq_d      = sq_q;
    qi_d      = qi_q;
    ri_d      = ri_q;
    wi_d      = wi_q;
    bi_d      = bi_q;
    j_d       = j_q;
    w_d       = w_q;
    b_d       = b_q;
    k_d       = k_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = w_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = wi_q;
    done_o      = 1'b0;

    tally_o       = '0;
    tally_o.start = accept;
    tally_o.seed  = lim_new >= LimW'(2);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          lim_d     = lim_new;
          klim_d    = (lim_new - LimW'(1)) >> 1;
          clamped_d = over_max;
          i_d       = IW'(3);
          sq_d      = SqW'(9);
          qi_d      = '0;
          ri_d      = BW'(3);
          wi_d      = '0;
          bi_d      = BW'(1);
          w_d       = '0;
          state_d   = ST_CLEAR;
        end
      end

      // Zero every bitmap word
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = w_q;
        ram_wdata_o = '0;
        w_d         = w_q + AW'(1);
        if (w_q == AW'(NumWords - 1)) begin
          if (lim_q < LimW'(3)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_OCHK;
          end
        end
      end

      // Outer loop bound, then fetch the word holding i
      ST_OCHK: begin
        if (sq_q > SqW'(lim_q)) begin
          w_d     = '0;
          b_d     = '0;
          k_d     = '0;
          state_d = ST_SRD;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = wi_q;
          state_d     = ST_OBIT;
        end
      end

      // i composite: skip; otherwise mark its odd multiples from 3i on
      ST_OBIT: begin
        if (ram_rdata_i[bi_q]) begin
          i_d     = i_nx;
          sq_d    = sq_nx;
          qi_d    = qi_nx;
          ri_d    = ri_nx;
          wi_d    = wi_nx;
          bi_d    = bi_nx;
          state_d = ST_OCHK;
        end else begin
          j_d     = JW'(i_q);
          w_d     = wi_q;
          b_d     = bi_q;
          state_d = ST_MRD;
        end
      end

      // Step to the next odd multiple and read its word; past the limit, next i
      ST_MRD: begin
        if (j_nx > JW'(lim_q)) begin
          i_d     = i_nx;
          sq_d    = sq_nx;
          qi_d    = qi_nx;
          ri_d    = ri_nx;
          wi_d    = wi_nx;
          bi_d    = bi_nx;
          state_d = ST_OCHK;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = w_nx;
          j_d         = j_nx;
          w_d         = w_nx;
          b_d         = b_nx;
          state_d     = ST_MWR;
        end
      end

      // Write back with the multiple's bit set
      ST_MWR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = w_q;
        ram_wdata_o = ram_rdata_i | (WordBits'(1) << b_q);
        state_d     = ST_MRD;
      end

      // Scan: fetch a word
      ST_SRD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = w_q;
        state_d     = ST_SBIT;
      end

      // Scan: one odd candidate per cycle within a word; bit 0 of word 0 is the number 1
      ST_SBIT: begin
        tally_o.step = 1'b1;
        tally_o.take = !ram_rdata_i[b_q] && (k_q != '0);
        if (k_q == klim_q) begin
          state_d = ST_DONE;
        end else begin
          k_d = k_q + LimW'(1);
          if (b_q == BW'(WordBits - 1)) begin
            b_d     = '0;
            w_d     = w_q + AW'(1);
            state_d = ST_SRD;
          end else begin
            b_d = b_q + BW'(1);
          end
        end
      end

      // Hand the result over once the output register is free
      ST_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    lim_q     <= lim_d;
    klim_q    <= klim_d;
    clamped_q <= clamped_d;
    i_q       <= i_d;
    sq_q      <= sq_d;
    qi_q      <= qi_d;
    ri_q      <= ri_d;
    wi_q      <= wi_d;
    bi_q      <= bi_d;
    j_q       <= j_d;
    w_q       <= w_d;
    b_q       <= b_d;
    k_q       <= k_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign clamped_o  = clamped_q;

endmodule

`default_nettype wire
